/* src/bpq_pkg.sv */
// ----------------------------------------------------------------------------
// bpq_pkg
// shared constants, types and helpers of the button press qualifier
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    localparam int PHASE_BITS = 3;
    localparam int OP_BITS    = 2;
    localparam int ADDR_BITS  = 1;

    localparam logic [PHASE_BITS-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_PRESSED  = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_VALID    = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_RELREQ   = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_DEBOUNCE = 3'd4;

    localparam logic [OP_BITS-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_CHECK  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FORCE  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_TICK   = 2'd3;

    localparam logic [ADDR_BITS-1:0] CFG_PRESS_HOLD = 1'd0;
    localparam logic [ADDR_BITS-1:0] CFG_DEBOUNCE   = 1'd1;

    localparam logic [CFG_BITS-1:0] PRESS_HOLD_RST = 16'd1000;
    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd50;

    typedef logic [PHASE_BITS-1:0] t_phase;

    typedef struct packed {
        logic start;
        logic stop;
        logic tick;
    } t_tmr_ctl;

    function automatic logic [TIMER_BITS-1:0] clamp_timeout(input logic [CFG_BITS-1:0] value);
        logic [CMP_BITS-1:0] wide;
        logic [CMP_BITS-1:0] top;
        wide = CMP_BITS'(value);
        top  = CMP_BITS'(CNT_MAX);
        if (wide > top) begin
            return CNT_MAX;
        end
        return wide[TIMER_BITS-1:0];
    endfunction

endpackage

/* src/bpq_timer.sv */
// ----------------------------------------------------------------------------
// bpq_timer
// saturating millisecond timer with latched timeout and match flag
// ----------------------------------------------------------------------------
module bpq_timer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bpq_pkg::t_tmr_ctl              i_ctl,
    input  logic [bpq_pkg::CFG_BITS-1:0]   i_timeout,
    output logic                           o_match
);

    logic [bpq_pkg::TIMER_BITS-1:0] r_elapsed, n_elapsed;
    logic [bpq_pkg::TIMER_BITS-1:0] r_limit, n_limit;
    logic                           r_running, n_running;

    always_comb begin
        n_elapsed = r_elapsed;
        n_limit   = r_limit;
        n_running = r_running;
        if (i_ctl.start) begin
            n_elapsed = '0;
            n_running = 1'b1;
            n_limit   = bpq_pkg::clamp_timeout(i_timeout);
        end else if (i_ctl.stop) begin
            n_elapsed = '0;
            n_running = 1'b0;
        end else if (i_ctl.tick && r_running && (r_elapsed != bpq_pkg::CNT_MAX)) begin
            n_elapsed = r_elapsed + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_limit   <= '0;
            r_running <= 1'b0;
        end else begin
            r_elapsed <= n_elapsed;
            r_limit   <= n_limit;
            r_running <= n_running;
        end
    end

    assign o_match = r_running && (r_elapsed >= r_limit);

endmodule

/* src/bpq_fsm.sv */
// ----------------------------------------------------------------------------
// bpq_fsm
// five-phase press state machine with release demand and timer control
// ----------------------------------------------------------------------------
module bpq_fsm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic [bpq_pkg::OP_BITS-1:0]       i_op,
    input  logic                              i_pressed,
    input  logic                              i_hold_match,
    input  logic                              i_deb_match,
    output bpq_pkg::t_tmr_ctl                 o_hold_ctl,
    output bpq_pkg::t_tmr_ctl                 o_deb_ctl,
    output logic                              o_reported,
    output bpq_pkg::t_phase                   o_phase
);

    bpq_pkg::t_phase r_phase, n_phase;
    logic            r_rel_dem, n_rel_dem;
    logic            reported;
    bpq_pkg::t_tmr_ctl hold_ctl, deb_ctl;

    always_comb begin
        n_phase   = r_phase;
        n_rel_dem = r_rel_dem;
        reported  = 1'b0;
        hold_ctl  = '0;
        deb_ctl   = '0;
        case (i_op)
            bpq_pkg::OP_SAMPLE: begin
                case (r_phase)
                    bpq_pkg::PH_IDLE: begin
                        if (i_pressed && !r_rel_dem) begin
                            hold_ctl.start = 1'b1;
                            n_phase        = bpq_pkg::PH_PRESSED;
                        end else begin
                            n_rel_dem = 1'b0;
                        end
                    end
                    bpq_pkg::PH_PRESSED: begin
                        if (!i_pressed) begin
                            hold_ctl.stop = 1'b1;
                            deb_ctl.start = 1'b1;
                            n_rel_dem     = 1'b0;
                            n_phase       = bpq_pkg::PH_DEBOUNCE;
                        end else if (r_rel_dem) begin
                            hold_ctl.stop = 1'b1;
                            n_rel_dem     = 1'b0;
                            n_phase       = bpq_pkg::PH_RELREQ;
                        end else if (i_hold_match) begin
                            hold_ctl.stop = 1'b1;
                            n_phase       = bpq_pkg::PH_VALID;
                        end
                    end
                    bpq_pkg::PH_VALID: begin
                        if (!i_pressed) begin
                            deb_ctl.start = 1'b1;
                            n_rel_dem     = 1'b0;
                            n_phase       = bpq_pkg::PH_DEBOUNCE;
                        end else if (r_rel_dem) begin
                            n_rel_dem = 1'b0;
                            n_phase   = bpq_pkg::PH_RELREQ;
                        end
                    end
                    bpq_pkg::PH_RELREQ: begin
                        if (!i_pressed) begin
                            deb_ctl.start = 1'b1;
                            n_rel_dem     = 1'b0;
                            n_phase       = bpq_pkg::PH_DEBOUNCE;
                        end else begin
                            n_rel_dem = 1'b0;
                        end
                    end
                    bpq_pkg::PH_DEBOUNCE: begin
                        if (i_deb_match) begin
                            deb_ctl.stop = 1'b1;
                            n_phase      = bpq_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            bpq_pkg::OP_CHECK: begin
                if ((r_phase == bpq_pkg::PH_VALID) && !r_rel_dem) begin
                    n_phase  = bpq_pkg::PH_RELREQ;
                    reported = 1'b1;
                end
            end
            bpq_pkg::OP_FORCE: begin
                n_rel_dem = 1'b1;
            end
            bpq_pkg::OP_TICK: begin
                hold_ctl.tick = 1'b1;
                deb_ctl.tick  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bpq_pkg::PH_RELREQ;
            r_rel_dem <= 1'b0;
        end else if (i_go) begin
            r_phase   <= n_phase;
            r_rel_dem <= n_rel_dem;
        end
    end

    // timer commands only take effect on a processed word
    assign o_hold_ctl = i_go ? hold_ctl : '0;
    assign o_deb_ctl  = i_go ? deb_ctl  : '0;
    assign o_reported = reported;
    assign o_phase    = n_phase;

endmodule

/* src/button_press_qualifier_unit.sv */
// ----------------------------------------------------------------------------
// button_press_qualifier_unit
// qualifies an active-low push button: hold time, forced release, debounce
// ----------------------------------------------------------------------------
// channel   dir  tdata (lsb first)                     tuser
// s_axis    in   pin_level[0], zero pad to 8 bits      operation[1:0]
// m_axis    out  press_reported[0], button_phase[3:1]  -
// cfg       in   0 press_hold_ms, 1 debounce_ms (16 bit write data)
//
// one word per cycle sustained while m_axis is not stalled; an accepted word
// passes through the input register and then the result register to m_axis
// the phase register loop closes once per processed word
// synchronous active-low reset; starts in release required
// a stalled m_axis holds its word; s_axis keeps taking words until the
// input register is also full
// ----------------------------------------------------------------------------
module button_press_qualifier_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // pin_level
    input  logic [bpq_pkg::OP_BITS-1:0]       i_s_axis_tuser,  // operation
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,  // press_reported, button_phase
    input  logic                              i_cfg_we,
    input  logic [bpq_pkg::ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [bpq_pkg::CFG_BITS-1:0]      i_cfg_wdata
);

    logic                          r_in_valid;
    logic [bpq_pkg::OP_BITS-1:0]   r_in_op;
    logic                          r_in_pin;
    logic                          r_out_valid;
    logic                          r_out_rep;
    bpq_pkg::t_phase               r_out_phase;
    logic [bpq_pkg::CFG_BITS-1:0]  r_hold_ms;
    logic [bpq_pkg::CFG_BITS-1:0]  r_deb_ms;

    logic              s_accept;
    logic              go;
    logic              hold_match, deb_match;
    bpq_pkg::t_tmr_ctl hold_ctl, deb_ctl;
    logic              reported;
    bpq_pkg::t_phase   phase;

    assign go              = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || go;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_op  <= i_s_axis_tuser;
            r_in_pin <= i_s_axis_tdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms <= bpq_pkg::PRESS_HOLD_RST;
            r_deb_ms  <= bpq_pkg::DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bpq_pkg::CFG_PRESS_HOLD: r_hold_ms <= i_cfg_wdata;
                bpq_pkg::CFG_DEBOUNCE:   r_deb_ms  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bpq_fsm u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_op         (r_in_op),
        .i_pressed    (!r_in_pin),
        .i_hold_match (hold_match),
        .i_deb_match  (deb_match),
        .o_hold_ctl   (hold_ctl),
        .o_deb_ctl    (deb_ctl),
        .o_reported   (reported),
        .o_phase      (phase)
    );

    bpq_timer u_hold_tmr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (hold_ctl),
        .i_timeout (r_hold_ms),
        .o_match   (hold_match)
    );

    bpq_timer u_deb_tmr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (deb_ctl),
        .i_timeout (r_deb_ms),
        .o_match   (deb_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_rep   <= reported;
            r_out_phase <= phase;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_phase, r_out_rep};

endmodule

/* src/bpq_checker.sv */
// ----------------------------------------------------------------------------
// bpq_checker
// port-level checks of the button press qualifier
// ----------------------------------------------------------------------------
module bpq_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_s_axis_tready,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [7:0]                    o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[3:1] <= bpq_pkg::PH_DEBOUNCE))
        else $error("phase code out of range");

    a_report_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0])
            |-> (o_m_axis_tdata[3:1] == bpq_pkg::PH_RELREQ))
        else $error("reported press not followed by release required");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("pipeline not empty after reset");

endmodule

bind button_press_qualifier_unit bpq_checker u_bpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
